// ===== rtl/grm_pkg.sv =====
// Shared constants, types and register codes for the Geiger rate meter.
// Every other file of the block imports this package; it depends on nothing.
package grm_pkg;

  localparam int AVG_DEPTH  = 10;

  localparam int FUNC_W     = 2;
  localparam int COUNT_W    = 16;
  localparam int CNT_W      = 32;
  localparam int INTERVAL_W = 16;
  localparam int DOSE_W     = 24;
  localparam int CFG_W      = 24;
  localparam int IDX_W      = 1;
  localparam int RATE_W     = 32;
  localparam int HELD_W     = 4;

  localparam int FILL_W = $clog2(AVG_DEPTH + 1);
  localparam int POS_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SUM_W  = CNT_W + FILL_W;

  localparam int MS_PER_SEC  = 1000;
  localparam int SEC_PER_MIN = 60;
  localparam int MS_PER_MIN  = 60000;
  localparam int MIN_W       = 16;
  localparam int SEC_W       = 23;
  localparam int FRAC_W      = 10;

  localparam int DIVD_W    = SUM_W + MIN_W;
  localparam int QUO_W     = 32;
  localparam int DIV_CNT_W = $clog2(QUO_W + 1);

  localparam int PROD_W  = RATE_W + DOSE_W;
  localparam int Q_SHIFT = 16;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd3000;
  localparam logic [DOSE_W-1:0]     DOSE_RESET     = 24'd373574;

  typedef logic [FUNC_W-1:0] func_t;
  localparam func_t FUNC_ADD     = 2'd0;
  localparam func_t FUNC_TICK    = 2'd1;
  localparam func_t FUNC_RESTART = 2'd2;

  localparam logic [IDX_W-1:0] REG_INTERVAL = 1'b0;
  localparam logic [IDX_W-1:0] REG_DOSE     = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0]  total;
    logic [SEC_W-1:0]  sec;
    logic [SUM_W-1:0]  sum;
    logic [FILL_W-1:0] fill;
  } grm_snap_t;

endpackage

// ===== rtl/grm_event_if.sv =====
// Input channel of the rate meter: valid/ready handshake with func and count.
// Depends on grm_pkg for the field widths.
interface grm_event_if import grm_pkg::*; ();
  logic               valid;
  logic               ready;
  func_t              func;
  logic [COUNT_W-1:0] count;

  modport source (output valid, func, count, input ready);
  modport sink   (input valid, func, count, output ready);
endinterface

// ===== rtl/grm_rate_if.sv =====
// Result channel of the rate meter: valid/ready handshake with the rates.
// Depends on grm_pkg for the field widths.
interface grm_rate_if import grm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] cpm_total;
  logic [RATE_W-1:0] dose_total;
  logic [RATE_W-1:0] cpm_average;
  logic [RATE_W-1:0] dose_average;
  logic [HELD_W-1:0] samples_held;

  modport source (output valid, cpm_total, dose_total, cpm_average, dose_average,
                  samples_held, input ready);
  modport sink   (input valid, cpm_total, dose_total, cpm_average, dose_average,
                  samples_held, output ready);
endinterface

// ===== rtl/grm_div.sv =====
// Radix-2 restoring divider with a saturating 32-bit quotient.
// Depends on grm_pkg for the operand widths.
module grm_div import grm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [QUO_W-1:0]  divisor,
  output logic              busy,
  output logic [QUO_W-1:0]  quotient
);

  localparam int HI_W = DIVD_W - QUO_W;

  logic [DIV_CNT_W-1:0] steps;
  logic [QUO_W-1:0]     rem;
  logic [QUO_W-1:0]     dvs;
  logic [QUO_W-1:0]     quo;
  logic [HI_W-1:0]      hi;
  logic                 fits;
  logic [QUO_W:0]       trial;
  logic [QUO_W:0]       diff;
  logic                 ge;

  assign hi    = dividend[DIVD_W-1:QUO_W];
  assign fits  = QUO_W'(hi) < divisor;
  assign trial = {rem, quo[QUO_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= (divisor != '0 && fits) ? DIV_CNT_W'(QUO_W) : '0;
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= QUO_W'(hi);
      if (divisor == '0) begin
        quo <= '0;
      end else if (!fits) begin
        quo <= '1;
      end else begin
        quo <= dividend[QUO_W-1:0];
      end
    end else if (steps != '0) begin
      rem <= ge ? diff[QUO_W-1:0] : trial[QUO_W-1:0];
      quo <= {quo[QUO_W-2:0], ge};
    end
  end

  assign busy     = steps != '0;
  assign quotient = quo;

endmodule

// ===== rtl/grm_state.sv =====
// Counter state and the ring of finished interval counts, held in a memory
// that is read at the transfer and written back in the cycle after it. Uses grm_pkg.
module grm_state import grm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic                  update,
  input  func_t                 func,
  input  logic [COUNT_W-1:0]    count,
  input  logic [INTERVAL_W-1:0] interval_ms,
  output grm_snap_t             snap
);

  localparam int BND_W = CNT_W + INTERVAL_W;

  logic [CNT_W-1:0]   ring [AVG_DEPTH];
  logic [CNT_W-1:0]   rd_data;
  func_t              func_q;
  logic [COUNT_W-1:0] count_q;
  logic [BND_W-1:0]   boundary;

  logic [CNT_W-1:0]   total;
  logic [CNT_W-1:0]   elapsed;
  logic [FRAC_W-1:0]  frac;
  logic [SEC_W-1:0]   sec;
  logic [CNT_W-1:0]   interval_events;
  logic [CNT_W-1:0]   interval_number;
  logic [POS_W-1:0]   write_pos;
  logic [FILL_W-1:0]  fill;
  logic [SUM_W-1:0]   sum;

  logic               past;
  logic               push;
  logic               restart;
  logic [CNT_W-1:0]   count_ext;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  assign count_ext = CNT_W'(count_q);
  assign past      = BND_W'(elapsed) >= boundary;
  assign push      = update && func_q == FUNC_ADD && past;
  assign restart   = update && func_q == FUNC_RESTART;

  always_ff @(posedge clk) begin
    if (take) begin
      func_q   <= func;
      count_q  <= count;
      boundary <= BND_W'(interval_number) * BND_W'(interval_ms);
      rd_data  <= ring[write_pos];
    end
    if (push) begin
      ring[write_pos] <= interval_events;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      total           <= '0;
      elapsed         <= '0;
      frac            <= '0;
      sec             <= '0;
      interval_events <= '0;
      interval_number <= CNT_W'(1);
      write_pos       <= '0;
      fill            <= '0;
      sum             <= '0;
    end else if (update) begin
      case (func_q)
        FUNC_ADD: begin
          total <= sat_add(total, count_ext);
          if (past) begin
            if (fill == FILL_W'(AVG_DEPTH)) begin
              sum <= sum - SUM_W'(rd_data) + SUM_W'(interval_events);
            end else begin
              fill <= fill + 1'b1;
              sum  <= sum + SUM_W'(interval_events);
            end
            write_pos <= (write_pos == POS_W'(AVG_DEPTH - 1)) ? '0 : write_pos + 1'b1;
            interval_events <= count_ext;
            if (interval_number != '1) begin
              interval_number <= interval_number + 1'b1;
            end
          end else begin
            interval_events <= sat_add(interval_events, count_ext);
          end
        end
        FUNC_TICK: begin
          if (elapsed != '1) begin
            elapsed <= elapsed + 1'b1;
            if (frac == FRAC_W'(MS_PER_SEC - 1)) begin
              frac <= '0;
              sec  <= sec + 1'b1;
            end else begin
              frac <= frac + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign snap.total = total;
  assign snap.sec   = sec;
  assign snap.sum   = sum;
  assign snap.fill  = fill;

  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(AVG_DEPTH))
    else $error("ring fill above depth");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    write_pos <= POS_W'(AVG_DEPTH - 1))
    else $error("ring write position out of range");

  a_fill_pos: assert property (@(posedge clk) disable iff (rst)
    fill != FILL_W'(AVG_DEPTH) |-> FILL_W'(write_pos) == fill)
    else $error("write position does not track fill while the ring fills");

endmodule

// ===== rtl/geiger_rate_meter.sv =====
// Top level of the Geiger rate meter: configuration, sequencer, dose scaling.
// Depends on grm_pkg, grm_event_if, grm_rate_if, grm_state and grm_div.
//
//   channel  direction  handshake     payload
//   events   in         valid/ready   func, count
//   rates    out        valid/ready   cpm_total, dose_total, cpm_average,
//                                     dose_average, samples_held
//   cfg      in         cfg_we        cfg_index, cfg_data
//
// An item waits on the 32-step radix-2 dividers, which run side by side, when a
// quotient needs them; with a zero divisor or a saturated quotient on both, the
// division state is passed without waiting.
// A new item is taken only in the idle state, entered in the cycle after the result
// is loaded; the result register lets the next item start while the previous result
// still waits on ready.
// Synchronous reset clears the counters and the ring control; the ring memory
// needs no clearing pass, so the block is ready in the cycle after reset.
module geiger_rate_meter import grm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  grm_event_if.sink         events,
  grm_rate_if.source        rates,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_UPDATE = 8'b00000010,
    S_PREP   = 8'b00000100,
    S_LOAD   = 8'b00001000,
    S_DIV    = 8'b00010000,
    S_DOSE_T = 8'b00100000,
    S_DOSE_A = 8'b01000000,
    S_DONE   = 8'b10000000
  } state_t;

  state_t                  state;
  state_t                  state_next;
  logic [INTERVAL_W-1:0]   interval_ms;
  logic [DOSE_W-1:0]       dose_factor;
  grm_snap_t               snap;
  logic                    take;
  logic                    out_free;

  logic [DIVD_W-1:0]       divd_t;
  logic [DIVD_W-1:0]       divd_a;
  logic [QUO_W-1:0]        dvs_t;
  logic [QUO_W-1:0]        dvs_a;
  logic                    busy_t;
  logic                    busy_a;
  logic [QUO_W-1:0]        cpm_t;
  logic [QUO_W-1:0]        cpm_a;
  logic [PROD_W-1:0]       prod;
  logic [RATE_W-1:0]       dose_t;

  logic                    out_valid;
  logic [RATE_W-1:0]       out_cpm_total;
  logic [RATE_W-1:0]       out_dose_total;
  logic [RATE_W-1:0]       out_cpm_average;
  logic [RATE_W-1:0]       out_dose_average;
  logic [HELD_W-1:0]       out_samples_held;

  function automatic logic [RATE_W-1:0] to_dose(input logic [PROD_W-1:0] p);
    if (p[PROD_W-1:RATE_W+Q_SHIFT] != '0) begin
      return '1;
    end
    return p[RATE_W+Q_SHIFT-1:Q_SHIFT];
  endfunction

  assign events.ready = state == S_IDLE && !rst;
  assign take         = events.valid && events.ready;
  assign out_free     = !out_valid || rates.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ms <= INTERVAL_RESET;
      dose_factor <= DOSE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INTERVAL: interval_ms <= cfg_data[INTERVAL_W-1:0];
        REG_DOSE:     dose_factor <= cfg_data[DOSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  grm_state u_state (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .update      (state == S_UPDATE),
    .func        (events.func),
    .count       (events.count),
    .interval_ms (interval_ms),
    .snap        (snap)
  );

  always_ff @(posedge clk) begin
    if (state == S_PREP) begin
      divd_t <= DIVD_W'(snap.total) * DIVD_W'(SEC_PER_MIN);
      dvs_t  <= QUO_W'(snap.sec);
      divd_a <= DIVD_W'(snap.sum) * DIVD_W'(MS_PER_MIN);
      dvs_a  <= QUO_W'(interval_ms) * QUO_W'(snap.fill);
    end
  end

  grm_div u_div_total (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_LOAD),
    .dividend (divd_t),
    .divisor  (dvs_t),
    .busy     (busy_t),
    .quotient (cpm_t)
  );

  grm_div u_div_average (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_LOAD),
    .dividend (divd_a),
    .divisor  (dvs_a),
    .busy     (busy_a),
    .quotient (cpm_a)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (take) state_next = S_UPDATE;
      S_UPDATE: state_next = S_PREP;
      S_PREP:   state_next = S_LOAD;
      S_LOAD:   state_next = S_DIV;
      S_DIV:    if (!busy_t && !busy_a) state_next = S_DOSE_T;
      S_DOSE_T: state_next = S_DOSE_A;
      S_DOSE_A: state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DOSE_T) begin
      prod <= PROD_W'(cpm_t) * PROD_W'(dose_factor);
    end else if (state == S_DOSE_A) begin
      dose_t <= to_dose(prod);
      prod   <= PROD_W'(cpm_a) * PROD_W'(dose_factor);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rates.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_cpm_total    <= cpm_t;
      out_dose_total   <= dose_t;
      out_cpm_average  <= cpm_a;
      out_dose_average <= to_dose(prod);
      out_samples_held <= HELD_W'(snap.fill);
    end
  end

  assign rates.valid        = out_valid;
  assign rates.cpm_total    = out_cpm_total;
  assign rates.dose_total   = out_dose_total;
  assign rates.cpm_average  = out_cpm_average;
  assign rates.dose_average = out_dose_average;
  assign rates.samples_held = out_samples_held;

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (busy_t || busy_a) |-> !events.ready)
    else $error("input ready while a division is running");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !out_valid) |=> out_valid)
    else $error("finished result not loaded into an empty output register");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (rates.valid && !rates.ready) |=> (rates.valid &&
      $stable({rates.cpm_total, rates.dose_total, rates.cpm_average,
               rates.dose_average, rates.samples_held})))
    else $error("waiting rate transfer changed before it was taken");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for geiger_rate_meter: random-gap traffic on both channels,
// register changes between phases, and an in-bench rate predictor checking every result.
// Depends on grm_pkg, grm_event_if, grm_rate_if and the geiger_rate_meter RTL.
module testbench;
  import grm_pkg::*;

  localparam func_t FUNC_UNUSED = 2'd3;
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  class rate_tracker;
    typedef struct packed {
      logic [RATE_W-1:0] cpm_total;
      logic [RATE_W-1:0] dose_total;
      logic [RATE_W-1:0] cpm_average;
      logic [RATE_W-1:0] dose_average;
      logic [HELD_W-1:0] held;
    } rate_set_t;

    bit [INTERVAL_W-1:0] interval;
    bit [DOSE_W-1:0]     factor;
    bit [CNT_W-1:0]      total;
    bit [CNT_W-1:0]      elapsed;
    bit [CNT_W-1:0]      interval_count;
    bit [CNT_W-1:0]      interval_no;
    bit [CNT_W-1:0]      ring_counts[AVG_DEPTH];
    int                  wpos;
    int                  fill;
    longint unsigned     ring_total;
    rate_set_t           pending_rates[$];
    int                  errors;
    int                  checked;

    function new();
      interval = INTERVAL_RESET;
      factor   = DOSE_RESET;
      errors   = 0;
      checked  = 0;
      clear();
    endfunction

    function void clear();
      total          = '0;
      elapsed        = '0;
      interval_count = '0;
      interval_no    = 1;
      foreach (ring_counts[i]) ring_counts[i] = '0;
      wpos       = 0;
      fill       = 0;
      ring_total = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == REG_INTERVAL) begin
        interval = value[INTERVAL_W-1:0];
      end else if (idx == REG_DOSE) begin
        factor = value[DOSE_W-1:0];
      end
    endfunction

    function bit [CNT_W-1:0] sat32(longint unsigned v);
      return (v > 64'hFFFF_FFFF) ? RATE_MAX : v[31:0];
    endfunction

    function bit [CNT_W-1:0] sat_add(bit [CNT_W-1:0] a, bit [CNT_W-1:0] b);
      longint unsigned s;
      s = 64'(a);
      s = s + 64'(b);
      return sat32(s);
    endfunction

    function bit [RATE_W-1:0] to_dose(bit [RATE_W-1:0] cpm);
      longint unsigned p;
      p = 64'(cpm);
      p = (p * 64'(factor)) >> Q_SHIFT;
      return sat32(p);
    endfunction

    function int pending();
      return pending_rates.size();
    endfunction

    function void note_input(func_t op, logic [COUNT_W-1:0] n);
      longint unsigned boundary;
      longint unsigned wide;
      longint unsigned den;
      bit [CNT_W-1:0]  sec;
      rate_set_t       want;
      case (op)
        FUNC_ADD: begin
          total = sat_add(total, CNT_W'(n));
          boundary = 64'(interval_no);
          boundary = boundary * 64'(interval);
          if (64'(elapsed) >= boundary) begin
            if (fill >= AVG_DEPTH) begin
              ring_total = ring_total - 64'(ring_counts[wpos]);
            end else begin
              fill++;
            end
            ring_counts[wpos] = interval_count;
            ring_total = ring_total + 64'(interval_count);
            wpos = (wpos == AVG_DEPTH - 1) ? 0 : wpos + 1;
            interval_count = CNT_W'(n);
            if (interval_no != RATE_MAX) interval_no++;
          end else begin
            interval_count = sat_add(interval_count, CNT_W'(n));
          end
        end
        FUNC_TICK: elapsed = sat_add(elapsed, CNT_W'(1));
        FUNC_RESTART: clear();
        default: ;
      endcase
      sec = elapsed / CNT_W'(MS_PER_SEC);
      want.cpm_total = '0;
      if (sec != 0) begin
        wide = 64'(total);
        wide = (wide * 64'(SEC_PER_MIN)) / 64'(sec);
        want.cpm_total = sat32(wide);
      end
      den = 64'(interval);
      den = den * 64'(fill);
      want.cpm_average = '0;
      if (den != 0) begin
        wide = (ring_total * 64'(MS_PER_MIN)) / den;
        want.cpm_average = sat32(wide);
      end
      want.dose_total   = to_dose(want.cpm_total);
      want.dose_average = to_dose(want.cpm_average);
      want.held         = HELD_W'(fill);
      pending_rates.push_back(want);
    endfunction

    function void compare(string field, logic [RATE_W-1:0] want, logic [RATE_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_rates(logic [RATE_W-1:0] cpm_t, logic [RATE_W-1:0] dose_t,
                              logic [RATE_W-1:0] cpm_a, logic [RATE_W-1:0] dose_a,
                              logic [HELD_W-1:0] held);
      rate_set_t want;
      if (pending_rates.size() == 0) begin
        errors++;
        $display("%0t: rate transfer with nothing expected, expected none, actual cpm %0d",
                 $time, cpm_t);
        return;
      end
      want = pending_rates.pop_front();
      checked++;
      compare("cpm_total", want.cpm_total, cpm_t);
      compare("dose_total", want.dose_total, dose_t);
      compare("cpm_average", want.cpm_average, cpm_a);
      compare("dose_average", want.dose_average, dose_a);
      compare("samples_held", RATE_W'(want.held), RATE_W'(held));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  grm_event_if events_if ();
  grm_rate_if  rates_if ();

  geiger_rate_meter i_dut (
    .clk       (clk),
    .rst       (rst),
    .events    (events_if),
    .rates     (rates_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rate_tracker board;
  int          sent = 0;
  int          settings = 0;
  int          src_calm = 0;
  int          snk_calm = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 19);
  endfunction

  task automatic send_item(func_t op, logic [COUNT_W-1:0] n);
    int gap;
    gap = draw_wait(src_calm);
    if (gap > 0) begin
      events_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    events_if.valid <= 1'b1;
    events_if.func  <= op;
    events_if.count <= n;
    do @(posedge clk); while (!events_if.ready);
    board.note_input(op, n);
    sent++;
  endtask

  task automatic drain();
    events_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic set_regs(logic [INTERVAL_W-1:0] iv, logic [DOSE_W-1:0] dv);
    cfg_we    <= 1'b1;
    cfg_index <= REG_INTERVAL;
    cfg_data  <= CFG_W'(iv);
    @(posedge clk);
    board.write_reg(REG_INTERVAL, CFG_W'(iv));
    cfg_index <= REG_DOSE;
    cfg_data  <= CFG_W'(dv);
    @(posedge clk);
    board.write_reg(REG_DOSE, CFG_W'(dv));
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic random_items(int items, bit allow_restart);
    int                 pick;
    logic [COUNT_W-1:0] n_ev;
    repeat (items) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: n_ev = COUNT_W'($urandom_range(0, 15));
        1: n_ev = COUNT_W'($urandom_range(0, 255));
        2: n_ev = '1;
        default: n_ev = COUNT_W'($urandom_range(0, 65535));
      endcase
      if (pick < 55) begin
        send_item(FUNC_TICK, n_ev);
      end else if (pick < 93) begin
        send_item(FUNC_ADD, n_ev);
      end else if (pick < 97 || !allow_restart) begin
        send_item(FUNC_UNUSED, n_ev);
      end else begin
        send_item(FUNC_RESTART, n_ev);
      end
    end
  endtask

  initial begin
    int stall;
    rates_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_wait(snk_calm);
      if (stall > 0) begin
        rates_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rates_if.ready <= 1'b1;
      do @(posedge clk); while (!rates_if.valid);
      board.check_rates(rates_if.cpm_total, rates_if.dose_total, rates_if.cpm_average,
                        rates_if.dose_average, rates_if.samples_held);
    end
  end

  initial begin
    logic [INTERVAL_W-1:0] iv;
    logic [DOSE_W-1:0]     dv;
    board = new();
    events_if.valid <= 1'b0;
    events_if.func  <= FUNC_ADD;
    events_if.count <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset register values first, then the shortest interval with the largest factor.
    send_item(FUNC_UNUSED, '1);
    send_item(FUNC_ADD, '0);
    send_item(FUNC_ADD, '1);
    send_item(FUNC_TICK, 16'hA5A5);
    send_item(FUNC_RESTART, 16'h5A5A);
    drain();
    set_regs(16'd1, '1);
    send_item(FUNC_ADD, '1);
    send_item(FUNC_ADD, '1);
    send_item(FUNC_TICK, '0);
    send_item(FUNC_ADD, 16'd1);
    send_item(FUNC_TICK, '1);
    send_item(FUNC_TICK, '0);
    send_item(FUNC_ADD, 16'h5A5A);
    send_item(FUNC_ADD, 16'd3);
    send_item(FUNC_TICK, 16'h00FF);
    send_item(FUNC_ADD, '0);
    send_item(FUNC_UNUSED, '0);
    send_item(FUNC_RESTART, '1);

    // Ticks, random items, then full-scale adds at maximal interval and factor.
    drain();
    set_regs(16'd7, '0);
    send_item(FUNC_RESTART, COUNT_W'($urandom_range(0, 65535)));
    repeat (30) send_item(FUNC_TICK, COUNT_W'($urandom_range(0, 65535)));
    random_items(50, 1'b0);
    drain();
    set_regs('1, '1);
    repeat (30) send_item(FUNC_ADD, '1);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case ($urandom_range(0, 5))
        0: iv = 16'd1;
        1: iv = '1;
        2: iv = INTERVAL_W'($urandom_range(2, 20));
        3: iv = INTERVAL_W'($urandom_range(1, 65535));
        default: iv = INTERVAL_W'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 3))
        0: dv = '0;
        1: dv = '1;
        default: dv = DOSE_W'($urandom_range(0, 16777215));
      endcase
      set_regs(iv, dv);
      if ($urandom_range(0, 1) == 1) begin
        send_item(FUNC_RESTART, COUNT_W'($urandom_range(0, 65535)));
      end
      random_items(60, 1'b1);
    end

    drain();
    repeat (64) @(posedge clk);
    $display("Sent %0d event transfers and checked %0d rate transfers under %0d settings,",
             sent, board.checked, settings);
    $display("including ring wrap, late adds, restarts and saturated rates.");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[geiger_rate_meter] OK");
    end else begin
      $display("[geiger_rate_meter] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Run did not complete in time.");
    $display("[geiger_rate_meter] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/grm_pkg.sv
rtl/grm_event_if.sv
rtl/grm_rate_if.sv
rtl/grm_div.sv
rtl/grm_state.sv
rtl/geiger_rate_meter.sv
verif/testbench.sv
